### sv/arp_responder_with_cache_core_defines.svh
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Clocked assertion wrappers used by the top-level core RTL file.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_WITH_CACHE_CORE_DEFINES_SVH
`define ARP_RESPONDER_WITH_CACHE_CORE_DEFINES_SVH

// Assertion on clk_i, off while rst_ni is low.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion on clk_i that also holds during reset.
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Codes, header constants and the token that moves along the cache chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpc_pkg;

  localparam logic [15:0] MIN_FRAME_LEN   = 16'd42;
  localparam logic [15:0] HW_TYPE_ETH     = 16'h0001;
  localparam logic [15:0] PROTO_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN     = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN  = 8'd4;
  localparam logic [15:0] OPER_REQUEST    = 16'd1;
  localparam logic [15:0] OPER_REPLY      = 16'd2;
  localparam logic [1:0]  FOP_REQUEST     = 2'd1;
  localparam logic [1:0]  FOP_REPLY       = 2'd2;
  localparam logic [47:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 8'd1;

  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_SEND    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_RESOLVE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_LEARN  = 2'd1,
    OP_LOOKUP = 2'd2
  } cache_op_e;

  typedef struct packed {
    logic        vld;
    cache_op_e   op;
    logic        done;
    logic        hit;
    logic [31:0] ip;
    logic [47:0] mac;
    kind_e       kind;
    logic [47:0] dst_mac;
    logic [1:0]  fop;
    logic [47:0] tgt_mac;
    logic [31:0] tgt_ip;
  } token_t;

endpackage

### sv/arpc_in_if.sv
// ----------------------------------------------------------------------------
// ARP input channel
// Valid/ready channel carrying one parsed packet or command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] frame_length;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_addr_len;
  logic [7:0]  proto_addr_len;
  logic [15:0] operation;
  logic [47:0] eth_src_mac;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [31:0] query_ip;

  modport source (
    output valid, cmd, frame_length, hw_type, proto_type, hw_addr_len,
           proto_addr_len, operation, eth_src_mac, sender_mac, sender_ip,
           target_ip, query_ip,
    input  ready
  );

  modport sink (
    input  valid, cmd, frame_length, hw_type, proto_type, hw_addr_len,
           proto_addr_len, operation, eth_src_mac, sender_mac, sender_ip,
           target_ip, query_ip,
    output ready
  );
endinterface

### sv/arpc_out_if.sv
// ----------------------------------------------------------------------------
// ARP result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [47:0] frame_dst_mac;
  logic [1:0]  frame_operation;
  logic [47:0] frame_target_mac;
  logic [31:0] frame_target_ip;
  logic        hit;
  logic [47:0] resolved_mac;

  modport source (
    output valid, result_kind, frame_dst_mac, frame_operation,
           frame_target_mac, frame_target_ip, hit, resolved_mac,
    input  ready
  );

  modport sink (
    input  valid, result_kind, frame_dst_mac, frame_operation,
           frame_target_mac, frame_target_ip, hit, resolved_mac,
    output ready
  );
endinterface

### sv/arpc_cfg_if.sv
// ----------------------------------------------------------------------------
// ARP configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/arpc_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// Holds one binding and processes the token passing through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpc_cell
  import arpc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  token_t tok_i,
  output token_t tok_o,
  output logic   ent_vld_o
);

  token_t      tok_d, tok_q;
  logic        ent_vld_q;
  logic [31:0] ent_ip_q;
  logic [47:0] ent_mac_q;
  logic        wr, fill, match;

  assign match = ent_vld_q && (ent_ip_q == tok_i.ip);

  always_comb begin
    tok_d = tok_i;
    wr    = 1'b0;
    fill  = 1'b0;
    if (tok_i.vld && !tok_i.done) begin
      case (tok_i.op)
        OP_LEARN: begin
          if (match) begin
            wr         = 1'b1;
            tok_d.done = 1'b1;
          end else if (!ent_vld_q) begin
            wr         = 1'b1;
            fill       = 1'b1;
            tok_d.done = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (match) begin
            tok_d.hit  = 1'b1;
            tok_d.mac  = ent_mac_q;
            tok_d.done = 1'b1;
          end else if (!ent_vld_q) begin
            tok_d.done = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      ent_vld_q <= 1'b0;
    end else if (en_i) begin
      tok_q <= tok_d;
      if (fill) ent_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr) begin
      ent_ip_q  <= tok_i.ip;
      ent_mac_q <= tok_i.mac;
    end
  end

  assign tok_o     = tok_q;
  assign ent_vld_o = ent_vld_q;

endmodule

### sv/arp_responder_with_cache_core.sv
// ----------------------------------------------------------------------------
// ARP responder with binding cache
// Path: an accepted input word passes through the register of every cache cell, in order, to its result.
// Throughput: one word per cycle; each cell of the cache chain takes one
// word per cycle, and the whole chain holds while a result waits.
// Reset: all entries invalid, own_ip and own_mac zero, no words in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arp_responder_with_cache_core_defines.svh"

module arp_responder_with_cache_core
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_in_if.sink    in_i,
  arpc_out_if.source out_o,
  arpc_cfg_if.sink   cfg_i
);

  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic        en;
  logic        well_formed;
  token_t      tok_in;
  token_t      tok [CACHE_ENTRIES+1];
  token_t      tok_last;
  logic [CACHE_ENTRIES-1:0] ent_vld;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_OWN_IP) own_ip_q <= cfg_i.data[31:0];
      if (cfg_i.index == REG_OWN_MAC) own_mac_q <= cfg_i.data;
    end
  end

  // Advance the chain unless the result word is stalled
  assign en         = !tok_last.vld || out_o.ready;
  assign in_i.ready = en;

  assign well_formed = (in_i.frame_length >= MIN_FRAME_LEN) &&
                       (in_i.hw_type == HW_TYPE_ETH) &&
                       (in_i.proto_type == PROTO_TYPE_IPV4) &&
                       (in_i.hw_addr_len == HW_ADDR_LEN) &&
                       (in_i.proto_addr_len == PROTO_ADDR_LEN);

  always_comb begin
    tok_in     = '0;
    tok_in.vld = in_i.valid;
    case (cmd_e'(in_i.cmd))
      CMD_RX: begin
        if (well_formed) begin
          if (in_i.operation == OPER_REPLY) begin
            tok_in.op  = OP_LEARN;
            tok_in.ip  = in_i.sender_ip;
            tok_in.mac = in_i.sender_mac;
          end else if (in_i.operation == OPER_REQUEST && in_i.target_ip == own_ip_q) begin
            tok_in.kind    = KIND_REPLY;
            tok_in.dst_mac = in_i.eth_src_mac;
            tok_in.fop     = FOP_REPLY;
            tok_in.tgt_mac = in_i.sender_mac;
            tok_in.tgt_ip  = in_i.sender_ip;
          end
        end
      end
      CMD_RESOLVE: begin
        tok_in.op   = OP_LOOKUP;
        tok_in.ip   = in_i.query_ip;
        tok_in.kind = KIND_RESOLVE;
      end
      CMD_SEND: begin
        tok_in.kind    = KIND_REQUEST;
        tok_in.dst_mac = BCAST_MAC;
        tok_in.fop     = FOP_REQUEST;
        tok_in.tgt_ip  = in_i.query_ip;
      end
      default: ;
    endcase
  end

  assign tok[0] = tok_in;

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    arpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .ent_vld_o (ent_vld[k])
    );
  end

  assign tok_last = tok[CACHE_ENTRIES];

  assign out_o.valid            = tok_last.vld;
  assign out_o.result_kind      = tok_last.kind;
  assign out_o.frame_dst_mac    = tok_last.dst_mac;
  assign out_o.frame_operation  = tok_last.fop;
  assign out_o.frame_target_mac = tok_last.tgt_mac;
  assign out_o.frame_target_ip  = tok_last.tgt_ip;
  assign out_o.hit              = tok_last.hit;
  assign out_o.resolved_mac     = (tok_last.op == OP_LOOKUP) ? tok_last.mac : '0;

  // Valid entries always form a block starting at entry zero
  `ARPC_ASSERT_ALWAYS(a_vld_prefix, ((ent_vld + 1'b1) & ent_vld) == '0, "cache entries not contiguous")
  // At most one entry fills per cycle and none is ever dropped
  `ARPC_ASSERT(a_fill_step, 1'b1 |=> ($countones(ent_vld) == $countones($past(ent_vld)) || $countones(ent_vld) == $countones($past(ent_vld)) + 1), "cache fill count jumped")
  // A hit only comes with a resolve answer
  `ARPC_ASSERT(a_hit_kind, out_o.valid && out_o.hit |-> out_o.result_kind == KIND_RESOLVE, "hit on a non-resolve word")

endmodule
